[rtl/b85_pkg.sv]
// b85_pkg: shared types, constants and helpers for the base-85 stream decoder
// no dependencies; used by b85_step and base85_stream_decoder
package b85_pkg;

  localparam logic [7:0] CharFirst = 8'h21;  // '!'
  localparam logic [7:0] CharLast  = 8'h75;  // 'u'
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChLf      = 8'h0a;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChFf      = 8'h0c;
  localparam logic [7:0] ChVt      = 8'h0b;

  localparam logic [2:0] GroupLen  = 3'd5;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
  localparam logic [1:0] ERR_SINGLE   = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [1:0] error_code;
    logic       run_last;
    logic       message_end;
  } out_word_t;

  // results of one item, sent word by word by the output stage
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  last_idx;
    logic        is_bytes;
    logic [1:0]  err;
    logic        msg_end;
  } bundle_t;

  function automatic logic [31:0] pow85(input logic [2:0] m);
    logic [31:0] p;
    case (m)
      3'd0:    p = 32'd1;
      3'd1:    p = 32'd85;
      3'd2:    p = 32'd7225;
      3'd3:    p = 32'd614125;
      3'd4:    p = 32'd52200625;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChLf) ||
           (c == ChCr) || (c == ChFf) || (c == ChVt);
  endfunction

endpackage

[rtl/b85_step.sv]
// b85_step: next group state and result bundle for one character
// depends on b85_pkg
module b85_step (
  input  logic              [31:0] acc_i,
  input  logic              [2:0]  cnt_i,
  input  logic                     drop_i,
  input  logic                     ign_ws_i,
  input  b85_pkg::in_word_t        word_i,
  output logic              [31:0] acc_o,
  output logic              [2:0]  cnt_o,
  output logic                     drop_o,
  output logic                     has_res_o,
  output b85_pkg::bundle_t         bundle_o
);

  logic        last;
  logic        skip;
  logic        is_digit;
  logic [6:0]  digit;
  logic [2:0]  cnt_new;
  logic [31:0] mul_p;
  logic [31:0] add_a;
  logic [31:0] pad_pow;
  logic [31:0] value;

  assign last     = word_i.end_of_input;
  assign skip     = ign_ws_i && b85_pkg::is_space(word_i.char_in);
  assign is_digit = !skip && (word_i.char_in >= b85_pkg::CharFirst) &&
                    (word_i.char_in <= b85_pkg::CharLast);
  assign digit    = 7'(word_i.char_in - b85_pkg::CharFirst);
  assign cnt_new  = is_digit ? 3'(cnt_i + 3'd1) : cnt_i;

  // padding with 'u' digits folds into acc*85^m + 85^m - 1
  always_comb begin
    pad_pow = b85_pkg::pow85(3'(3'd4 - cnt_i));
    if (is_digit && !last) begin
      mul_p = 32'd85;
      add_a = {25'd0, digit};
    end else if (is_digit) begin
      mul_p = b85_pkg::pow85(3'(b85_pkg::GroupLen - cnt_i));
      add_a = 32'({25'd0, digit} * pad_pow) + pad_pow - 32'd1;
    end else begin
      mul_p = b85_pkg::pow85(3'(b85_pkg::GroupLen - cnt_i));
      add_a = b85_pkg::pow85(3'(b85_pkg::GroupLen - cnt_i)) - 32'd1;
    end
  end

  assign value = 32'(acc_i * mul_p) + add_a;

  always_comb begin
    acc_o              = acc_i;
    cnt_o              = cnt_i;
    drop_o             = drop_i;
    has_res_o          = 1'b0;
    bundle_o.value     = value;
    bundle_o.last_idx  = 2'd0;
    bundle_o.is_bytes  = 1'b0;
    bundle_o.err       = b85_pkg::ERR_NONE;
    bundle_o.msg_end   = last;
    if (drop_i) begin
      drop_o = !last;
    end else if (!skip && !is_digit) begin
      acc_o            = '0;
      cnt_o            = '0;
      drop_o           = !last;
      has_res_o        = 1'b1;
      bundle_o.err     = b85_pkg::ERR_BAD_CHAR;
      bundle_o.msg_end = 1'b1;
    end else if (cnt_new == b85_pkg::GroupLen) begin
      acc_o             = '0;
      cnt_o             = '0;
      has_res_o         = 1'b1;
      bundle_o.is_bytes = 1'b1;
      bundle_o.last_idx = 2'd3;
    end else if (last) begin
      acc_o     = '0;
      cnt_o     = '0;
      has_res_o = 1'b1;
      if (cnt_new == 3'd1) begin
        bundle_o.err = b85_pkg::ERR_SINGLE;
      end else if (cnt_new != 3'd0) begin
        bundle_o.is_bytes = 1'b1;
        bundle_o.last_idx = 2'(cnt_new - 3'd2);
      end
    end else if (is_digit) begin
      acc_o = value;
      cnt_o = cnt_new;
    end
  end

endmodule

[rtl/base85_stream_decoder.sv]
// base85_stream_decoder: streaming base-85 decoder, one character in, up to four bytes out
// depends on b85_pkg and b85_step
//
//   port group   direction  handshake              payload
//   in_*         input      in_valid_i/in_stall_o   b85_pkg::in_word_t
//   out_*        output     out_valid_o/out_stall_i b85_pkg::out_word_t
//   cfg_*        input      cfg_we_i                cfg_wdata_i (ignore whitespace)
//
// a character is registered, then decoded combinationally into a result bundle
// the bundle register sends one word per cycle while out_stall_i is low, so a group
// of five digits yields four output words; characters with no result pass at one per cycle
// a new bundle loads in the cycle the last word of the old one is taken
// reset clears group state, error dropping and the config bit
module base85_stream_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b85_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b85_pkg::out_word_t  out_word_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  logic              ign_ws_q;
  logic              in_vld_q, in_vld_d;
  b85_pkg::in_word_t in_q;
  logic [31:0]       acc_q, acc_d;
  logic [2:0]        cnt_q, cnt_d;
  logic              drop_q, drop_d;
  logic              has_res;
  b85_pkg::bundle_t  bnd_new;
  b85_pkg::bundle_t  bnd_q;
  logic              bnd_vld_q;
  logic [1:0]        idx_q;
  logic              out_take;
  logic              out_done;
  logic              bnd_free;
  logic              s1_fire;
  logic              in_take;

  b85_step u_step (
    .acc_i     (acc_q),
    .cnt_i     (cnt_q),
    .drop_i    (drop_q),
    .ign_ws_i  (ign_ws_q),
    .word_i    (in_q),
    .acc_o     (acc_d),
    .cnt_o     (cnt_d),
    .drop_o    (drop_d),
    .has_res_o (has_res),
    .bundle_o  (bnd_new)
  );

  assign out_take   = bnd_vld_q && !out_stall_i;
  assign out_done   = out_take && (idx_q == bnd_q.last_idx);
  assign bnd_free   = !bnd_vld_q || out_done;
  assign s1_fire    = in_vld_q && (!has_res || bnd_free);
  assign in_stall_o = in_vld_q && !s1_fire;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_take || (in_vld_q && !s1_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_ws_q <= 1'b0;
    end else if (cfg_we_i) begin
      ign_ws_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      acc_q    <= '0;
      cnt_q    <= '0;
      drop_q   <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
      if (s1_fire) begin
        acc_q  <= acc_d;
        cnt_q  <= cnt_d;
        drop_q <= drop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (s1_fire && has_res) begin
      bnd_vld_q <= 1'b1;
      idx_q     <= '0;
    end else if (out_done) begin
      bnd_vld_q <= 1'b0;
      idx_q     <= '0;
    end else if (out_take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && has_res) begin
      bnd_q <= bnd_new;
    end
  end

  // big-endian byte select from the group word
  always_comb begin
    out_word_o.data_byte   = '0;
    out_word_o.byte_valid  = bnd_q.is_bytes;
    out_word_o.error_code  = bnd_q.err;
    out_word_o.run_last    = (idx_q == bnd_q.last_idx);
    out_word_o.message_end = (idx_q == bnd_q.last_idx) && bnd_q.msg_end;
    if (bnd_q.is_bytes) begin
      out_word_o.data_byte = 8'(bnd_q.value >> (5'd24 - {idx_q, 3'b000}));
    end
  end

  assign out_valid_o = bnd_vld_q;

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bnd_vld_q |-> idx_q <= bnd_q.last_idx)
    else $error("result index past end of bundle");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < b85_pkg::GroupLen)
    else $error("digit count reached a full group");

  a_drop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> (cnt_q == 3'd0) && (acc_q == 32'd0))
    else $error("group state not cleared while dropping");

  a_single_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bnd_vld_q && !bnd_q.is_bytes) |-> bnd_q.last_idx == 2'd0)
    else $error("error or marker bundle with more than one word");

  a_no_lost_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && has_res) |-> bnd_free)
    else $error("bundle overwritten before fully sent");

endmodule
